>>> src/csv_field_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Used by cft_front.sv and cft_back.sv; compiled out when SYNTHESIS is defined.
`ifndef CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset
`define CFT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cft: invariant violated");

// Antecedent true implies consequent in the same cycle
`define CFT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cft: implication violated");

`else

`define CFT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define CFT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/cft_pkg.sv
// Package for the CSV field tokenizer: types, codes and constants.
// No dependencies; used by the queue, front, back, top level and testbench.
package cft_pkg;

    // Default depth of the trailing-whitespace hold store
    localparam int HOLD_DEPTH_DEFAULT = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FEND = 2'd1;
    localparam logic [1:0] KIND_LEND = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEP   = 2'd0;
    localparam logic [1:0] CFG_QUOTE = 2'd1;
    localparam logic [1:0] CFG_ESC   = 2'd2;

    // Register reset values and fixed characters
    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] ESC_RESET   = 8'd92;
    localparam logic [7:0] SPACE_CHAR  = 8'd32;

    // Operations handed from front to back
    typedef enum logic [1:0] {
        OP_WS   = 2'd0,  // whitespace inside content: hold it
        OP_CHAR = 2'd1,  // content character: flush held, then send it
        OP_FEND = 2'd2,  // end of field
        OP_LEND = 2'd3   // end of line, optionally closing an open field
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       fend;
    } t_qent;

    // Whitespace set: 9..13, 32, 133, 160
    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) ||
               (c == 8'd133) || (c == 8'd160);
    endfunction

endpackage

>>> src/cft_if.sv
// Channel interfaces of the tokenizer: input items, results, configuration writes.
// Depends on nothing; used by the top level and the front and back modules.
interface cft_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface cft_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       trim_overflow;
    logic       last;

    modport source (output valid, output kind, output out_char, output trim_overflow,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_char, input trim_overflow,
                    input last, output ready);
endinterface

interface cft_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/cft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/cft_queue.sv
// Short operation queue between the tokenizer front and back.
// Depends on cft_pkg (entry type and depth).
module cft_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cft_pkg::t_qent i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cft_pkg::t_qent o_head
);

    localparam int AW = cft_pkg::QUEUE_AW;

    cft_pkg::t_qent r_slot [cft_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == (AW+1)'(cft_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> src/cft_front.sv
// Tokenizer front: configuration registers, field phase tracking, item classification.
// Depends on cft_pkg, cft_if.sv and the assertion macro header.
`include "csv_field_tokenizer_core_assert.svh"

module cft_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cft_in_if.sink         i_in,
    cft_cfg_if.sink        i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output cft_pkg::t_qent o_push_data
);

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_QUOTED = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    logic [7:0] r_sep;
    logic [7:0] r_quote;
    logic [7:0] r_esc_char;

    t_phase r_phase, n_phase;
    logic   r_field_open, n_field_open;
    logic   r_esc_pend, n_esc_pend;
    logic   r_content_seen, n_content_seen;

    logic       in_acc;
    logic       plain_char;
    logic       do_content;
    logic [7:0] c;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign c           = i_in.ch;

    // Classify the accepted transaction and update field state
    always_comb begin
        n_phase        = r_phase;
        n_field_open   = r_field_open;
        n_esc_pend     = r_esc_pend;
        n_content_seen = r_content_seen;
        o_push         = 1'b0;
        o_push_data    = '{op: cft_pkg::OP_FEND, ch: c, fend: 1'b0};
        plain_char     = 1'b0;
        do_content     = 1'b0;

        if (in_acc) begin
            if (i_in.cmd) begin
                o_push           = 1'b1;
                o_push_data.op   = cft_pkg::OP_LEND;
                o_push_data.fend = r_field_open;
                n_phase          = PH_LEAD;
                n_field_open     = 1'b0;
                n_esc_pend       = 1'b0;
                n_content_seen   = 1'b0;
            end else if (r_esc_pend) begin
                n_esc_pend = 1'b0;
                do_content = 1'b1;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (c == cft_pkg::SPACE_CHAR) begin
                            // leading space skipped
                        end else if (c == r_quote) begin
                            n_field_open = 1'b1;
                            n_phase      = PH_QUOTED;
                        end else begin
                            n_phase    = PH_PLAIN;
                            plain_char = 1'b1;
                        end
                    end
                    PH_PLAIN: begin
                        plain_char = 1'b1;
                    end
                    PH_QUOTED: begin
                        if (c == r_quote) begin
                            n_phase = PH_SKIP;
                        end else if (c == r_esc_char) begin
                            n_esc_pend = 1'b1;
                        end else begin
                            do_content = 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        if (c == r_sep) begin
                            o_push         = 1'b1;
                            o_push_data.op = cft_pkg::OP_FEND;
                            n_phase        = PH_LEAD;
                            n_field_open   = 1'b0;
                            n_content_seen = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_LEAD;
                    end
                endcase

                // Unquoted field: separator first, then escape
                if (plain_char) begin
                    if (c == r_sep) begin
                        o_push         = 1'b1;
                        o_push_data.op = cft_pkg::OP_FEND;
                        n_phase        = PH_LEAD;
                        n_field_open   = 1'b0;
                        n_content_seen = 1'b0;
                    end else if (c == r_esc_char) begin
                        n_field_open = 1'b1;
                        n_esc_pend   = 1'b1;
                    end else begin
                        do_content = 1'b1;
                    end
                end
            end

            // Content: whitespace is held only after real content
            if (do_content) begin
                if (cft_pkg::is_ws(c)) begin
                    if (r_content_seen) begin
                        o_push         = 1'b1;
                        o_push_data.op = cft_pkg::OP_WS;
                    end
                end else begin
                    n_field_open   = 1'b1;
                    n_content_seen = 1'b1;
                    o_push         = 1'b1;
                    o_push_data.op = cft_pkg::OP_CHAR;
                end
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep          <= cft_pkg::SEP_RESET;
            r_quote        <= cft_pkg::QUOTE_RESET;
            r_esc_char     <= cft_pkg::ESC_RESET;
            r_phase        <= PH_LEAD;
            r_field_open   <= 1'b0;
            r_esc_pend     <= 1'b0;
            r_content_seen <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_field_open   <= n_field_open;
            r_esc_pend     <= n_esc_pend;
            r_content_seen <= n_content_seen;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    cft_pkg::CFG_SEP:   r_sep      <= i_cfg.data;
                    cft_pkg::CFG_QUOTE: r_quote    <= i_cfg.data;
                    cft_pkg::CFG_ESC:   r_esc_char <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // A pending escape, seen content or a quoted phase always belongs to an open field
    `CFT_ASSERT_IMPLY(a_esc_open, i_clk, i_rst_n, r_esc_pend, r_field_open)
    `CFT_ASSERT_IMPLY(a_content_open, i_clk, i_rst_n, r_content_seen, r_field_open)
    `CFT_ASSERT_IMPLY(a_quoted_open, i_clk, i_rst_n,
        (r_phase == PH_QUOTED) || (r_phase == PH_SKIP), r_field_open)

endmodule

>>> src/cft_back.sv
// Tokenizer back: trailing-whitespace hold ring, held-character flush, result register.
// Depends on cft_pkg, cft_if.sv, cft_ram and the assertion macro header.
`include "csv_field_tokenizer_core_assert.svh"

module cft_back #(
    parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  cft_pkg::t_qent i_head,
    output logic           o_pop,
    cft_out_if.source      o_out
);

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(HOLD_DEPTH);
    localparam logic [CW-1:0] CNT_FULL = CW'(HOLD_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_FLUSH = 3'd1,
        S_CHAR  = 3'd2,
        S_OVF   = 3'd3,
        S_LEND  = 3'd4
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_ch, n_ch;

    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_char;
    logic       r_tov;
    logic       r_last;

    logic          out_free;
    logic          load;
    logic [1:0]    ld_kind;
    logic [7:0]    ld_char;
    logic          ld_tov;
    logic          ld_last;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [CW-1:0] idx_next;

    // Ring address: base plus offset, both below the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    cft_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign idx_next = r_idx + CW'(1);

    // Operation sequencing
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        n_ch    = r_ch;
        o_pop   = 1'b0;
        load    = 1'b0;
        ld_kind = cft_pkg::KIND_CHAR;
        ld_char = 8'd0;
        ld_tov  = 1'b0;
        ld_last = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_head;
        wr_data = i_head.ch;
        rd_en   = 1'b0;
        rd_addr = r_head;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_head.op)
                        cft_pkg::OP_WS: begin
                            o_pop = 1'b1;
                            if (r_cnt < CNT_FULL) begin
                                wr_en   = 1'b1;
                                wr_addr = ring_add(r_head, (AW+1)'(r_cnt));
                                n_cnt   = r_cnt + CW'(1);
                            end else begin
                                // full: oldest goes out, new one takes its slot
                                rd_en   = 1'b1;
                                n_ch    = i_head.ch;
                                n_state = S_OVF;
                            end
                        end
                        cft_pkg::OP_CHAR: begin
                            if (r_cnt != '0) begin
                                o_pop   = 1'b1;
                                rd_en   = 1'b1;
                                n_idx   = '0;
                                n_ch    = i_head.ch;
                                n_state = S_FLUSH;
                            end else if (out_free) begin
                                o_pop   = 1'b1;
                                load    = 1'b1;
                                ld_char = i_head.ch;
                                ld_last = 1'b1;
                            end
                        end
                        cft_pkg::OP_FEND: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                load    = 1'b1;
                                ld_kind = cft_pkg::KIND_FEND;
                                ld_tov  = r_ovf;
                                ld_last = 1'b1;
                                n_cnt   = '0;
                                n_ovf   = 1'b0;
                            end
                        end
                        cft_pkg::OP_LEND: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                load  = 1'b1;
                                n_cnt = '0;
                                n_ovf = 1'b0;
                                if (i_head.fend) begin
                                    ld_kind = cft_pkg::KIND_FEND;
                                    ld_tov  = r_ovf;
                                    n_state = S_LEND;
                                end else begin
                                    ld_kind = cft_pkg::KIND_LEND;
                                    ld_last = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                // one held character per cycle while the output is free, next read issued alongside
                if (out_free) begin
                    load    = 1'b1;
                    ld_char = rd_data;
                    if (idx_next == r_cnt) begin
                        n_cnt   = '0;
                        n_state = S_CHAR;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ring_add(r_head, (AW+1)'(idx_next));
                        n_idx   = idx_next;
                    end
                end
            end
            S_CHAR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_char = r_ch;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OVF: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_char = rd_data;
                    ld_last = 1'b1;
                    wr_en   = 1'b1;
                    wr_data = r_ch;
                    n_head  = ring_add(r_head, (AW+1)'(1));
                    n_ovf   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LEND: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = cft_pkg::KIND_LEND;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            r_ch    <= n_ch;
            if (load) begin
                r_out_valid <= 1'b1;
                r_kind      <= ld_kind;
                r_char      <= ld_char;
                r_tov       <= ld_tov;
                r_last      <= ld_last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.out_char      = r_char;
    assign o_out.trim_overflow = r_tov;
    assign o_out.last          = r_last;

    `CFT_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_FULL)
    `CFT_ASSERT_IMPLY(a_flush_idx, i_clk, i_rst_n, r_state == S_FLUSH, r_idx < r_cnt)
    `CFT_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, r_state == S_OVF, r_cnt == CNT_FULL)
    `CFT_ASSERT_IMPLY(a_lend_last, i_clk, i_rst_n,
        r_out_valid && (r_kind == cft_pkg::KIND_LEND), r_last)

endmodule

>>> src/csv_field_tokenizer_core.sv
// CSV field tokenizer top level: front, operation queue and back.
// Depends on cft_pkg, cft_if.sv, cft_front, cft_queue, cft_back.

// Items enter at up to one per cycle: the front classifies each character or
// end-of-line item in the cycle it is accepted and places at most one operation
// in a four-entry queue. The back works the queue off: a field end, a line end
// or a content character with nothing held gives one result, and a field end
// closed by an end-of-line item gives a field-end result, then a line-end
// result. Whitespace inside a field is held in a HOLD_DEPTH-entry RAM; a
// following content character first starts the read, then sends each held
// character and then the character itself. Whitespace beyond a full hold store
// first reads the store, then sends the oldest character. The held-character
// RAM port sets the flush rate; the input stalls only while the queue is full.
// The hold store needs no clearing after reset.
module csv_field_tokenizer_core #(
    parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cft_in_if.sink     i_in,
    cft_cfg_if.sink    i_cfg,
    cft_out_if.source  o_out
);

    logic           push;
    cft_pkg::t_qent push_data;
    logic           full;
    logic           pop;
    logic           empty;
    cft_pkg::t_qent head;

    cft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    cft_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_head      (head)
    );

    cft_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> dv/tb_csv_field_tokenizer_core.sv
// Self-checking testbench for csv_field_tokenizer_core: directed and random lines under
// several register settings, checked against an in-bench field tokenizer model.
// Depends on cft_pkg, cft_if.sv and the RTL of the tokenizer.
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_core;

    localparam int HOLD            = cft_pkg::HOLD_DEPTH_DEFAULT;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic       CMD_CHAR   = 1'b0;
    localparam logic       CMD_EOL    = 1'b1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Characters used by the directed lines and the random blank and text choices
    localparam logic [7:0] BLANK_LO  = 8'd9;
    localparam logic [7:0] BLANK_HI  = 8'd13;
    localparam logic [7:0] NEL_CHAR  = 8'd133;
    localparam logic [7:0] NBSP_CHAR = 8'd160;
    localparam logic [7:0] LETTER_A  = 8'h61;

    typedef enum logic [1:0] {
        TP_LEAD,
        TP_PLAIN,
        TP_QUOTED,
        TP_AFTER_QUOTE
    } t_tok_phase;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_SPARSE,
        RX_COIN,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       trim_overflow;
        logic       last;
    } t_token;

    logic i_clk;
    logic i_rst_n;

    cft_in_if  in_if ();
    cft_out_if out_if ();
    cft_cfg_if cfg_if ();

    csv_field_tokenizer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Tokenizer model state and register copies
    logic [7:0] sep_q;
    logic [7:0] quote_q;
    logic [7:0] esc_q;
    t_tok_phase phase_q;
    logic       field_open_q;
    logic       esc_pend_q;
    logic       content_q;
    logic       ovf_q;
    logic [7:0] held_q [HOLD];
    int         held_n;

    t_token expected_tokens[$];
    t_token step_tokens[$];

    int errors = 0;
    int n_items;
    int n_lines;
    int n_tokens = 0;
    int n_cfg;
    int burst_left;
    int hold_left;
    int cycles;

    event holdoff_go;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still due", cycles,
                         expected_tokens.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= BLANK_LO) && (c <= BLANK_HI)) || (c == cft_pkg::SPACE_CHAR) ||
               (c == NEL_CHAR) || (c == NBSP_CHAR);
    endfunction

    // ---------------------------------------------------------------
    // Tokenizer model
    // ---------------------------------------------------------------
    task automatic add_token(input logic [1:0] kind, input logic [7:0] c, input logic ovf);
        t_token t;
        t.kind          = kind;
        t.out_char      = (kind == cft_pkg::KIND_CHAR) ? c : 8'd0;
        t.trim_overflow = (kind == cft_pkg::KIND_FEND) && ovf;
        t.last          = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic reset_field();
        phase_q      = TP_LEAD;
        field_open_q = 1'b0;
        esc_pend_q   = 1'b0;
        content_q    = 1'b0;
        held_n       = 0;
        ovf_q        = 1'b0;
    endtask

    task automatic close_field();
        add_token(cft_pkg::KIND_FEND, 8'd0, ovf_q);
        reset_field();
    endtask

    // Content path: blanks are held for trimming, anything else flushes them
    task automatic take_content(input logic [7:0] c);
        int i;
        if (is_blank(c)) begin
            if (!content_q)
                return;
            if (held_n < HOLD) begin
                held_q[held_n] = c;
                held_n++;
            end else begin
                add_token(cft_pkg::KIND_CHAR, held_q[0], 1'b0);
                for (i = 1; i < HOLD; i++)
                    held_q[i-1] = held_q[i];
                held_q[HOLD-1] = c;
                ovf_q          = 1'b1;
            end
            return;
        end
        field_open_q = 1'b1;
        for (i = 0; i < held_n; i++)
            add_token(cft_pkg::KIND_CHAR, held_q[i], 1'b0);
        held_n    = 0;
        content_q = 1'b1;
        add_token(cft_pkg::KIND_CHAR, c, 1'b0);
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == sep_q)
            close_field();
        else if (c == esc_q) begin
            field_open_q = 1'b1;
            esc_pend_q   = 1'b1;
        end else
            take_content(c);
    endtask

    task automatic take_line_char(input logic [7:0] c);
        if (esc_pend_q) begin
            esc_pend_q = 1'b0;
            take_content(c);
            return;
        end
        case (phase_q)
            TP_LEAD: begin
                if (c == cft_pkg::SPACE_CHAR) begin
                    // leading space: skipped
                end else if (c == quote_q) begin
                    field_open_q = 1'b1;
                    phase_q      = TP_QUOTED;
                end else begin
                    phase_q = TP_PLAIN;
                    plain_char(c);
                end
            end
            TP_PLAIN: plain_char(c);
            TP_QUOTED: begin
                if (c == quote_q)
                    phase_q = TP_AFTER_QUOTE;
                else if (c == esc_q)
                    esc_pend_q = 1'b1;
                else
                    take_content(c);
            end
            default: begin
                // text after the closing quote is dropped up to the separator
                if (c == sep_q)
                    close_field();
            end
        endcase
    endtask

    // Expected results of one accepted input transaction
    task automatic predict_item(input logic cmd, input logic [7:0] c);
        step_tokens.delete();
        if (cmd == CMD_CHAR)
            take_line_char(c);
        else begin
            if (field_open_q)
                close_field();
            reset_field();
            add_token(cft_pkg::KIND_LEND, 8'd0, 1'b0);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // One input transaction; the sender runs in bursts with random gaps
    task automatic send_item(input logic cmd, input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.ch    <= c;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predict_item(cmd, c);
        n_items++;
        if (cmd == CMD_EOL)
            n_lines++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        // whitespace may still be in flight with nothing due
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        n_cfg++;
        case (idx)
            cft_pkg::CFG_SEP:   sep_q   = val;
            cft_pkg::CFG_QUOTE: quote_q = val;
            cft_pkg::CFG_ESC:   esc_q   = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input logic [7:0] sep, input logic [7:0] quote,
                             input logic [7:0] esc);
        write_reg(cft_pkg::CFG_SEP, sep);
        write_reg(cft_pkg::CFG_QUOTE, quote);
        write_reg(cft_pkg::CFG_ESC, esc);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(CMD_CHAR, s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: return 8'(BLANK_LO + $urandom_range(0, 4));
            5:             return cft_pkg::SPACE_CHAR;
            6:             return NEL_CHAR;
            default:       return NBSP_CHAR;
        endcase
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'(LETTER_A + $urandom_range(0, 25));
            3:       return pick_blank();
            4:       return cft_pkg::SPACE_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed lines with random content, some noise lines
    task automatic send_random_line();
        int nfields;
        int len;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 8))
                send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
        end else begin
            nfields = $urandom_range(0, 4);
            for (int f = 0; f < nfields; f++) begin
                repeat ($urandom_range(0, 2))
                    send_item(CMD_CHAR, cft_pkg::SPACE_CHAR);
                if ($urandom_range(0, 2) == 0) begin
                    // quoted field, may hold separators and escapes
                    send_item(CMD_CHAR, quote_q);
                    len = $urandom_range(0, 5);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 5))
                            0: begin
                                send_item(CMD_CHAR, esc_q);
                                send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
                            end
                            1:       send_item(CMD_CHAR, sep_q);
                            default: send_item(CMD_CHAR, pick_text());
                        endcase
                    end
                    if ($urandom_range(0, 4) != 0)
                        send_item(CMD_CHAR, quote_q);
                    repeat ($urandom_range(0, 2))
                        send_item(CMD_CHAR, pick_text());
                end else begin
                    len = $urandom_range(0, 6);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_item(CMD_CHAR, esc_q);
                            send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
                        end else
                            send_item(CMD_CHAR, pick_text());
                    end
                end
                // trailing blanks, now and then past the hold depth
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(HOLD - 2, HOLD + 4)
                                                  : $urandom_range(0, 3);
                repeat (len)
                    send_item(CMD_CHAR, pick_blank());
                if ((f < nfields - 1) || ($urandom_range(0, 3) == 0))
                    send_item(CMD_CHAR, sep_q);
            end
            if ($urandom_range(0, 5) == 0)
                send_item(CMD_CHAR, esc_q);
        end
        send_item(CMD_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random_lines(input int count);
        int start;
        start = n_items;
        while (n_items - start < count)
            send_random_line();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset codes: empty line, quoting, escapes, empty fields, trimming
    task automatic test_directed_defaults();
        send_item(CMD_EOL, 8'h00);
        // space, "a\"" then junk z, separator, escape at line end
        send_item(CMD_CHAR, cft_pkg::SPACE_CHAR);
        send_item(CMD_CHAR, cft_pkg::QUOTE_RESET);
        send_text("a");
        send_item(CMD_CHAR, cft_pkg::ESC_RESET);
        send_item(CMD_CHAR, cft_pkg::QUOTE_RESET);
        send_item(CMD_CHAR, cft_pkg::QUOTE_RESET);
        send_text("z");
        send_item(CMD_CHAR, cft_pkg::SEP_RESET);
        send_item(CMD_CHAR, cft_pkg::ESC_RESET);
        send_item(CMD_EOL, 8'h00);
        // empty field, leading non-space blank, trailing blanks dropped
        send_item(CMD_CHAR, cft_pkg::SEP_RESET);
        send_item(CMD_CHAR, NBSP_CHAR);
        send_text("b");
        send_item(CMD_CHAR, BLANK_LO);
        send_item(CMD_CHAR, NEL_CHAR);
        send_item(CMD_EOL, 8'hFF);
    endtask

    // More trailing blanks than the hold store keeps
    task automatic test_hold_overflow();
        send_text("q");
        repeat (HOLD + 1)
            send_item(CMD_CHAR, pick_blank());
        send_item(CMD_EOL, 8'h5A);
    endtask

    task automatic test_extreme_codes();
        set_codes(8'h00, 8'hFF, 8'h80);
        run_random_lines(1);
        set_codes(8'hFF, 8'h00, 8'h7F);
        run_random_lines(1);
    endtask

    // All codes equal: the per-phase check order decides
    task automatic test_coinciding_codes();
        set_codes(cft_pkg::SEP_RESET, cft_pkg::SEP_RESET, cft_pkg::SEP_RESET);
        write_reg(CFG_UNUSED, 8'hA5);
        send_text("a,b,,c");
        send_item(CMD_EOL, 8'h00);
        run_random_lines(1);
    endtask

    task automatic test_random_codes();
        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        run_random_lines(1);
    endtask

    // Long output hold-off while the sender keeps offering a long line
    task automatic test_output_holdoff();
        set_codes(cft_pkg::SEP_RESET, cft_pkg::QUOTE_RESET, cft_pkg::ESC_RESET);
        -> holdoff_go;
        repeat (12) begin
            send_item(CMD_CHAR, 8'(LETTER_A + $urandom_range(0, 25)));
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_CHAR, cft_pkg::SEP_RESET);
        end
        send_item(CMD_EOL, 8'h00);
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern of its own, overridden by the hold-off
    // ---------------------------------------------------------------
    // Hold-off counter: started by the test, counted down once per cycle
    initial begin
        hold_left = 0;
        forever begin
            @(holdoff_go);
            hold_left <= HOLD_OFF_CYCLES;
            repeat (HOLD_OFF_CYCLES) begin
                @(posedge i_clk);
                hold_left <= hold_left - 1;
            end
        end
    end

    initial begin
        t_rx_mode rx_mode;
        int       mode_timer;
        int       tick;
        out_if.ready = 1'b0;
        rx_mode      = RX_STEADY;
        mode_timer   = 0;
        tick         = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (mode_timer == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                mode_timer = $urandom_range(20, 120);
            end
            mode_timer--;
            if (hold_left != 0)
                out_if.ready <= 1'b0;
            else begin
                case (rx_mode)
                    RX_STEADY: out_if.ready <= 1'b1;
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                    default:   out_if.ready <= ((tick % 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at result %0d (cycle %0d): %s expected %h got %h",
                 n_tokens, cycles, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind          = out_if.kind;
            got.out_char      = out_if.out_char;
            got.trim_overflow = out_if.trim_overflow;
            got.last          = out_if.last;
            n_tokens++;
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected result, kind", 8'h00, 8'(got.kind));
            else begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 8'(want.kind), 8'(got.kind));
                if (got.out_char !== want.out_char)
                    report_mismatch("out_char", want.out_char, got.out_char);
                if (got.trim_overflow !== want.trim_overflow)
                    report_mismatch("trim_overflow", 8'(want.trim_overflow),
                                    8'(got.trim_overflow));
                if (got.last !== want.last)
                    report_mismatch("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        in_if.valid  = 1'b0;
        in_if.cmd    = CMD_CHAR;
        in_if.ch     = 8'd0;
        cfg_if.valid = 1'b0;
        cfg_if.index = cft_pkg::CFG_SEP;
        cfg_if.data  = 8'd0;
        i_rst_n      = 1'b0;
        n_items      = 0;
        n_lines      = 0;
        n_cfg        = 0;
        burst_left   = 0;
        sep_q        = cft_pkg::SEP_RESET;
        quote_q      = cft_pkg::QUOTE_RESET;
        esc_q        = cft_pkg::ESC_RESET;
        foreach (held_q[i])
            held_q[i] = 8'd0;
        reset_field();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_hold_overflow();
        run_random_lines(6);
        test_extreme_codes();
        test_coinciding_codes();
        test_random_codes();
        test_output_holdoff();

        wait_idle();
        $display("%0d input items in %0d lines, %0d results checked, %0d register writes",
                 n_items, n_lines, n_tokens, n_cfg);
        $display("codes: reset, extremes, all equal, random; hold overflow; %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/cft_pkg.sv
src/cft_if.sv
src/cft_ram.sv
src/cft_queue.sv
src/cft_front.sv
src/cft_back.sv
src/csv_field_tokenizer_core.sv
dv/tb_csv_field_tokenizer_core.sv
